>>> rtl/cwwm_pkg.sv
// ----------------------------------------------------------------------------
// cwwm_pkg
// Shared types and constants for the concatenated word window matcher.
// ----------------------------------------------------------------------------
package cwwm_pkg;

  localparam int CHAR_W    = 8;
  localparam int WORD_REGS = 6;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_WORD_LEN   = 3'd0;
  localparam reg_idx_t REG_WORD_COUNT = 3'd1;
  localparam reg_idx_t REG_WORD_0     = 3'd2;
  localparam reg_idx_t REG_WORD_5     = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_CHUNK
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [WORD_REGS-1:0] pick;
  } cmp_res_t;

endpackage

>>> rtl/concatenated_word_window_match.sv
// ----------------------------------------------------------------------------
// concatenated_word_window_match
// Streams text one character per item and reports the start index of every
// window that is an arrangement of all configured words.
// ----------------------------------------------------------------------------
// An item that does not complete a full window is done once it is accepted. An
// item that completes a window is accepted, then its window is aligned in the
// shift unit, then checked chunk by chunk (at most word_count chunks, with
// word_count taken as 1 to 6), because a single comparator checks one chunk
// against all words per cycle. The first chunk
// that finds no word ends the item in that cycle. A result waits in an output
// register, so the next item is taken while it waits; the last chunk cycle
// holds only when an earlier result is still not taken.
module concatenated_word_window_match #(
  parameter int MAX_WORDS    = 6,
  parameter int MAX_WORD_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] match_start
);
  import cwwm_pkg::*;

  localparam int DEPTH   = MAX_WORDS * MAX_WORD_LEN;
  localparam int CNT_LIM = (MAX_WORDS < WORD_REGS) ? MAX_WORDS : WORD_REGS;
  localparam int SH_W    = $clog2(DEPTH + 1);
  localparam int WORD_W  = MAX_WORD_LEN * CHAR_W;

  logic [3:0]                          word_len;
  logic [2:0]                          word_count;
  logic [WORD_REGS-1:0][WORD_W-1:0]    words;
  logic [DEPTH-1:0][CHAR_W-1:0]        history;
  logic [DEPTH-1:0][CHAR_W-1:0]        work;
  logic [31:0]                         char_count;
  logic [WORD_REGS-1:0]                used;
  logic [2:0]                          chunk_idx;
  state_t                              state;
  state_t                              state_next;

  logic [3:0]                          len_eff;
  logic [2:0]                          cnt_eff;
  logic [6:0]                          win;
  logic [31:0]                         count_inc;
  logic                                win_reached;
  logic                                last;
  logic                                align;
  logic                                step;
  logic                                finish;
  logic [SH_W-1:0]                     shamt;
  logic [DEPTH-1:0][CHAR_W-1:0]        shift_src;
  logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] chunk;
  cmp_res_t                            cmp;

  always_comb begin
    if (word_len == 4'd0) begin
      len_eff = 4'd1;
    end else if (int'(word_len) > MAX_WORD_LEN) begin
      len_eff = 4'(MAX_WORD_LEN);
    end else begin
      len_eff = word_len;
    end
    if (word_count == 3'd0) begin
      cnt_eff = 3'd1;
    end else if (int'(word_count) > CNT_LIM) begin
      cnt_eff = 3'(CNT_LIM);
    end else begin
      cnt_eff = word_count;
    end
  end

  assign win         = {3'b000, len_eff} * {4'b0000, cnt_eff};
  assign count_inc   = (first ? 32'd0 : char_count) + 32'd1;
  assign win_reached = count_inc >= {25'd0, win};
  assign last        = chunk_idx == (cnt_eff - 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_len   <= 4'd3;
      word_count <= 3'd3;
      words      <= '0;
    end else if (cfg_write) begin
      case (cfg_index) inside
        REG_WORD_LEN:             word_len   <= cfg_data[3:0];
        REG_WORD_COUNT:           word_count <= cfg_data[2:0];
        [REG_WORD_0:REG_WORD_5]:  words[cfg_index - REG_WORD_0] <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      char_count <= '0;
    end else if (in_valid && in_ready) begin
      history[0] <= char_in;
      for (int i = 1; i < DEPTH; i++) begin
        history[i] <= history[i-1];
      end
      char_count <= count_inc;
    end
  end

  // Shared byte shifter: aligns the oldest window byte to the top, then
  // moves one chunk up per cycle while a chunk matches and more remain.
  assign shift_src = align ? history : work;
  assign shamt     = align ? (SH_W'(DEPTH) - SH_W'(win)) : SH_W'(len_eff);

  always_comb begin
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      chunk[j] = work[DEPTH-1-j];
    end
  end

  cwwm_chunk_cmp #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_cmp (
    .chunk (chunk),
    .words (words),
    .len   (len_eff),
    .cnt   (cnt_eff),
    .used  (used),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (align || step) begin
      work <= shift_src << {shamt, 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      chunk_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (align) begin
        used      <= '0;
        chunk_idx <= '0;
      end else if (step) begin
        used      <= used | cmp.pick;
        chunk_idx <= chunk_idx + 3'd1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      match_start <= char_count - {25'd0, win};
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    align      = 1'b0;
    step       = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && win_reached) begin
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        align      = 1'b1;
        state_next = ST_CHUNK;
      end
      ST_CHUNK: begin
        if (!cmp.found) begin
          state_next = ST_IDLE;
        end else if (!last) begin
          step = 1'b1;
        end else if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_chunk_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHUNK |-> chunk_idx < cnt_eff)
    else $error("chunk index beyond word count");

  a_used_tracks_chunks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHUNK |-> $countones(used) == int'(chunk_idx))
    else $error("used word count differs from chunks matched");

  a_short_text_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !win_reached) |=> state == ST_IDLE)
    else $error("window judged before enough characters arrived");

endmodule

>>> rtl/cwwm_chunk_cmp.sv
// ----------------------------------------------------------------------------
// cwwm_chunk_cmp
// Compares one window chunk against all configured words and picks the
// first equal word that is still unused.
// ----------------------------------------------------------------------------
module cwwm_chunk_cmp #(
  parameter int MAX_WORD_LEN = 8
) (
  input  logic [MAX_WORD_LEN-1:0][cwwm_pkg::CHAR_W-1:0]                 chunk,
  input  logic [cwwm_pkg::WORD_REGS-1:0][MAX_WORD_LEN*cwwm_pkg::CHAR_W-1:0] words,
  input  logic [3:0]                                                    len,
  input  logic [2:0]                                                    cnt,
  input  logic [cwwm_pkg::WORD_REGS-1:0]                                used,
  output cwwm_pkg::cmp_res_t                                            res
);
  import cwwm_pkg::*;

  logic [WORD_REGS-1:0] cand;

  always_comb begin
    for (int w = 0; w < WORD_REGS; w++) begin
      cand[w] = (w < int'(cnt)) && !used[w];
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
        if ((j < int'(len)) && (chunk[j] != words[w][CHAR_W*j +: CHAR_W])) begin
          cand[w] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.found = 1'b0;
    res.pick  = '0;
    for (int w = 0; w < WORD_REGS; w++) begin
      if (cand[w] && !res.found) begin
        res.found   = 1'b1;
        res.pick[w] = 1'b1;
      end
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// concatenated_word_window_match testbench
// Streams directed and random text through the matcher under changing word
// settings. A local scoreboard predicts every window match and compares each
// reported start index in order, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cwwm_pkg::*;

  localparam int MAX_WORDS    = 6;
  localparam int MAX_WORD_LEN = 8;
  localparam int HIST_DEPTH   = MAX_WORDS * MAX_WORD_LEN;
  localparam int ITEM_TARGET  = 1750;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] ch;
    logic       fst;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = '0;
  logic        first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] match_start;

  concatenated_word_window_match uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_in(char_in),
    .first(first),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .match_start(match_start)
  );

  always #1 clk = ~clk;

  // Scoreboard copy of the registers and the text state.
  logic [3:0]  cfg_len = 4'd3;
  logic [2:0]  cfg_cnt = 3'd3;
  logic [63:0] cfg_words [WORD_REGS];
  logic [7:0]  hist [HIST_DEPTH];
  logic [31:0] text_pos = '0;
  logic [31:0] window_starts [$];

  char_item_t  text_q [$];
  char_item_t  draft [$];
  char_item_t  cur_item;

  int          idle_pct = 20;
  bit          calm = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          alpha_mode = 0;
  logic [7:0]  alpha_base = '0;

  int          errors = 0;
  int          chars_sent = 0;
  int          matches_seen = 0;
  int          pushed = 0;
  int          settings_used = 0;
  int          win_min = HIST_DEPTH;
  int          win_max = 0;
  int          quiet_cycles = 0;

  initial begin
    for (int i = 0; i < WORD_REGS; i++) cfg_words[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
  end

  function automatic int unsigned span_len(input logic [3:0] raw);
    return (raw == 0) ? 1 : ((raw > MAX_WORD_LEN) ? MAX_WORD_LEN : raw);
  endfunction

  function automatic int unsigned span_count(input logic [2:0] raw);
    return (raw == 0) ? 1 : ((raw > MAX_WORDS) ? MAX_WORDS : raw);
  endfunction

  function automatic char_item_t make_char(input logic [7:0] ch, input logic fst);
    char_item_t item;
    item.ch = ch;
    item.fst = fst;
    return item;
  endfunction

  function automatic void add_char(input char_item_t item);
    draft = {draft, item};
  endfunction

  function automatic logic [7:0] pick_char();
    case (alpha_mode)
      0: return 8'($urandom);
      1: return alpha_base + 8'($urandom_range(0, 2));
      default: return $urandom_range(0, 1) ? alpha_base : ~alpha_base;
    endcase
  endfunction

  // Shift one character into the history and record the start of the window
  // if its chunks can each claim a distinct configured word.
  function automatic void scan_char(input logic [7:0] ch, input logic fst);
    int unsigned len, cnt, win, c, w, j;
    logic [WORD_REGS-1:0] taken;
    bit found, same;
    len = span_len(cfg_len);
    cnt = span_count(cfg_cnt);
    win = len * cnt;
    if (fst) text_pos = '0;
    for (j = HIST_DEPTH - 1; j > 0; j--) hist[j] = hist[j-1];
    hist[0] = ch;
    text_pos = text_pos + 1;
    if (text_pos < win) return;
    taken = '0;
    for (c = 0; c < cnt; c++) begin
      found = 1'b0;
      for (w = 0; w < cnt && !found; w++) begin
        if (!taken[w]) begin
          same = 1'b1;
          for (j = 0; j < len; j++) begin
            if (hist[win - 1 - (c * len + j)] != cfg_words[w][8*j +: 8]) same = 1'b0;
          end
          if (same) begin
            taken[w] = 1'b1;
            found = 1'b1;
          end
        end
      end
      if (!found) return;
    end
    window_starts = {window_starts, 32'(text_pos - win)};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        scan_char(cur_item.ch, cur_item.fst);
        chars_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          cur_item = text_q.pop_front();
          char_in <= cur_item.ch;
          first <= cur_item.fst;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (window_starts.size() == 0) begin
          $error("match_start: no match expected, actual %0d", match_start);
          errors++;
        end else begin
          want = window_starts.pop_front();
          matches_seen++;
          if (match_start !== want) begin
            $error("match_start: expected %0d, actual %0d", want, match_start);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        recv_gap = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("concatenated_word_window_match verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WORD_LEN:   cfg_len = data[3:0];
      REG_WORD_COUNT: cfg_cnt = data[2:0];
      default:        cfg_words[idx - REG_WORD_0] = data;
    endcase
  endtask

  // Hold off until every character is taken, the block is idle and every
  // match has come back.
  task automatic settle();
    @(negedge clk);
    while (text_q.size() != 0 || in_valid || !in_ready || window_starts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic feed(input int unsigned n);
    int unsigned i;
    char_item_t item;
    for (i = 0; i < n && draft.size() > 0; i++) begin
      item = draft.pop_front();
      text_q = {text_q, item};
      pushed++;
    end
  endtask

  task automatic random_setup();
    logic [63:0] data;
    logic [3:0]  len_raw;
    logic [2:0]  cnt_raw;
    int unsigned w, j, win;
    alpha_mode = $urandom_range(0, 2);
    alpha_base = 8'($urandom);
    case ($urandom_range(0, 5))
      0: len_raw = 4'd0;
      1: len_raw = 4'd15;
      2: len_raw = 4'd1;
      3: len_raw = 4'd8;
      default: len_raw = 4'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 5))
      0: cnt_raw = 3'd0;
      1: cnt_raw = 3'd7;
      2: cnt_raw = 3'd1;
      3: cnt_raw = 3'd6;
      default: cnt_raw = 3'($urandom_range(0, 7));
    endcase
    for (w = 0; w < WORD_REGS; w++) begin
      if (w > 0 && $urandom_range(0, 3) == 0) begin
        data = cfg_words[$urandom_range(0, w - 1)];
      end else begin
        data = {$urandom, $urandom};
        for (j = 0; j < MAX_WORD_LEN; j++) data[8*j +: 8] = pick_char();
      end
      write_reg(reg_idx_t'(REG_WORD_0 + w), data);
    end
    data = {$urandom, $urandom};
    data[3:0] = len_raw;
    write_reg(REG_WORD_LEN, data);
    data = {$urandom, $urandom};
    data[2:0] = cnt_raw;
    write_reg(REG_WORD_COUNT, data);
    settings_used++;
    win = span_len(cfg_len) * span_count(cfg_cnt);
    if (win < win_min) win_min = win;
    if (win > win_max) win_max = win;
  endtask

  // Mostly arrangements of the configured words, some with one byte spoiled,
  // mixed with short runs of noise and the odd new text.
  task automatic compose_text(input int unsigned target);
    int unsigned len, cnt, i, j, k, t, start;
    int unsigned perm [MAX_WORDS];
    char_item_t item;
    len = span_len(cfg_len);
    cnt = span_count(cfg_cnt);
    draft.delete();
    while (draft.size() < target) begin
      start = draft.size();
      if ($urandom_range(0, 99) < 65) begin
        for (i = 0; i < cnt; i++) perm[i] = i;
        for (i = cnt - 1; i > 0; i--) begin
          k = $urandom_range(0, i);
          t = perm[i];
          perm[i] = perm[k];
          perm[k] = t;
        end
        for (i = 0; i < cnt; i++) begin
          for (j = 0; j < len; j++) add_char(make_char(cfg_words[perm[i]][8*j +: 8], 1'b0));
        end
        if ($urandom_range(0, 99) < 15) begin
          k = start + $urandom_range(0, len * cnt - 1);
          item = draft[k];
          item.ch = pick_char();
          draft[k] = item;
        end
      end else begin
        k = $urandom_range(1, 2 * len);
        for (i = 0; i < k; i++) add_char(make_char(pick_char(), 1'b0));
      end
      if ($urandom_range(0, 99) < 5) begin
        item = draft[start];
        item.fst = 1'b1;
        draft[start] = item;
      end
    end
  endtask

  initial begin
    int unsigned i, phase;
    logic [63:0] data;
    logic [7:0]  dup_words [WORD_REGS];
    dup_words[0] = "x";
    dup_words[1] = "y";
    dup_words[2] = "x";
    dup_words[3] = "x";
    dup_words[4] = "z";
    dup_words[5] = "y";
    phase = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings match a window of nine zero bytes; no first flag yet.
    for (i = 0; i < 9; i++) add_char(make_char(8'h00, 1'b0));
    add_char(make_char(8'hFF, 1'b0));
    feed(draft.size());
    settle();

    // Oversized length and zero count: a single eight byte word.
    write_reg(REG_WORD_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_WORD_COUNT, 64'h0);
    write_reg(REG_WORD_0, 64'hFE7F_0180_5AA5_00FF);
    for (i = 0; i < MAX_WORD_LEN; i++) add_char(make_char(cfg_words[0][8*i +: 8], i == 0));
    feed(draft.size());
    settle();

    // Zero length and oversized count with repeated words, mid text.
    write_reg(REG_WORD_LEN, 64'h0);
    write_reg(REG_WORD_COUNT, 64'h7);
    for (i = 0; i < WORD_REGS; i++) begin
      data = {$urandom, $urandom};
      data[7:0] = dup_words[i];
      write_reg(reg_idx_t'(REG_WORD_0 + i), data);
    end
    add_char(make_char("x", 1'b0));
    add_char(make_char("x", 1'b0));
    add_char(make_char("y", 1'b0));
    add_char(make_char("x", 1'b0));
    add_char(make_char("z", 1'b0));
    add_char(make_char("y", 1'b0));
    add_char(make_char("x", 1'b0));
    feed(draft.size());
    settle();

    while (pushed < ITEM_TARGET) begin
      calm = (pushed >= ITEM_TARGET - 250);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      random_setup();
      compose_text($urandom_range(60, 140));
      if (phase % 4 == 2) begin
        feed(draft.size() / 2);
        settle();
      end
      feed(draft.size());
      settle();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (window_starts.size() != 0) begin
      $error("match_start: %0d expected matches never arrived", window_starts.size());
      errors++;
    end
    $display("Sent %0d characters under %0d random word settings, windows of %0d to %0d.",
             chars_sent, settings_used, win_min, win_max);
    $display("Compared %0d reported window starts, %0d errors.", matches_seen, errors);
    if (errors == 0) begin
      $display("concatenated_word_window_match verification clean");
    end else begin
      $display("concatenated_word_window_match verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cwwm_pkg.sv
rtl/cwwm_chunk_cmp.sv
rtl/concatenated_word_window_match.sv
tb/testbench.sv
